### rtl/bblc_pkg.sv
// Shared constants and types for the byte budget LRU cache.
`default_nettype none
package bblc_pkg;
    localparam int ENTRIES   = 32;
    localparam int PIN_SLOTS = 16;
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = $clog2(PIN_SLOTS);
    localparam int EPW = 128;

    localparam logic [3:0] CMD_INSERT  = 4'd0;
    localparam logic [3:0] CMD_TOUCH   = 4'd1;
    localparam logic [3:0] CMD_LOOKUP  = 4'd2;
    localparam logic [3:0] CMD_CLRPIN  = 4'd3;
    localparam logic [3:0] CMD_ADDPIN  = 4'd4;
    localparam logic [3:0] CMD_TRIM    = 4'd5;
    localparam logic [3:0] CMD_RETAIN  = 4'd6;
    localparam logic [3:0] CMD_REMOVE  = 4'd7;
    localparam logic [3:0] CMD_CLEAR   = 4'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PINFULL = 2'd3;

    localparam logic [0:0] ADDR_BUDGET = 1'b0;

    localparam logic [36:0] BUDGET_RESET = 37'd268435456;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] item_id;
        logic [31:0] item_bytes;
    } t_cmd;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] result_id;
        logic        hit;
        logic [36:0] byte_total;
        logic [1:0]  status;
        logic        last;
    } t_res;
endpackage
`default_nettype wire

### rtl/bblc_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface bblc_cmd_if import bblc_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bblc_res_if import bblc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/bblc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module bblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/byte_budget_lru_cache.sv
// Top level: command sequencer over entry and pin memories.
//
//  channel | dir | handshake          | word
//  cmd     | in  | valid/ready        | command, item_id, item_bytes
//  res     | out | valid/ready        | kind, id, hit, bytes, status, last
//  cfg     | in  | APB, pready high   | budget_bytes at 0x0 (64-bit data)
//
// A key search reads every entry of the entry memory in turn, through S_FIND and S_FINDW.
// An LRU or remove scan steps past each free entry and, for each valid entry, reads every
// pin slot in turn through S_PINCK and S_PINW; an eviction passes through S_EVRD, S_EVWT
// and S_EVOUT, and a trim rescans from the first entry after each eviction.
// Reset clears valid, retain and pin-valid flops at once. Input is taken only when
// idle; a word waiting on o_res stalls the next eviction or completion word.
`default_nettype none
module byte_budget_lru_cache import bblc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bblc_cmd_if.sink         i_cmd,
    bblc_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_FINDW = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_LRU   = 4'd4;
    localparam logic [3:0] S_PINCK = 4'd5;
    localparam logic [3:0] S_PINW  = 4'd6;
    localparam logic [3:0] S_LRUN  = 4'd7;
    localparam logic [3:0] S_EVRD  = 4'd8;
    localparam logic [3:0] S_EVWT  = 4'd9;
    localparam logic [3:0] S_EVOUT = 4'd10;
    localparam logic [3:0] S_WRITE = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_PINFD = 4'd13;
    localparam logic [3:0] S_PINFW = 4'd14;

    localparam logic [1:0] G_INS   = 2'd0;
    localparam logic [1:0] G_TRIM  = 2'd1;
    localparam logic [1:0] G_REM   = 2'd2;

    logic [3:0]        r_st;
    t_cmd              r_cmd;
    logic [36:0]       r_budget, r_total;
    logic [63:0]       r_cnt;
    logic [ENTRIES-1:0] r_ev, r_er;
    logic [PIN_SLOTS-1:0] r_pv;
    logic [EW:0]       r_i;
    logic [PW:0]       r_p;
    logic [EW:0]       r_nev;
    logic [EW-1:0]     r_hit_idx, r_best;
    logic [31:0]       r_hit_size;
    logic              r_found, r_has_best, r_pinned;
    logic [63:0]       r_best_st;
    logic [1:0]        r_goal, r_status;
    t_res              r_res;
    logic              r_rv;

    logic              e_we;
    logic [EW-1:0]     e_wa, e_ra;
    logic [EPW-1:0]    e_wd, e_rd;
    logic              p_we;
    logic [PW-1:0]     p_wa, p_ra;
    logic [31:0]       p_wd, p_rd;

    bblc_ram #(.WIDTH(EPW), .DEPTH(ENTRIES)) u_ent (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));
    bblc_ram #(.WIDTH(32), .DEPTH(PIN_SLOTS)) u_pin (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd));

    logic [31:0] rd_key, rd_size;
    logic [63:0] rd_stamp;
    assign rd_key   = e_rd[31:0];
    assign rd_size  = e_rd[63:32];
    assign rd_stamp = e_rd[127:64];

    assign pready = 1'b1;
    assign prdata = {27'd0, r_budget};
    assign i_cmd.ready = (r_st == S_IDLE);
    assign o_res.valid = r_rv;
    assign o_res.data  = r_res;

    logic [EW-1:0] ii;
    logic [PW-1:0] pp;
    assign ii = r_i[EW-1:0];
    assign pp = r_p[PW-1:0];

    logic          free_ok;
    logic [EW-1:0] free_idx;
    logic          pin_free_ok;
    logic [PW-1:0] pin_free_idx;
    always_comb begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!r_ev[k]) begin
                free_ok = 1'b1;
                free_idx = EW'(k);
            end
        end
        pin_free_ok = 1'b0;
        pin_free_idx = '0;
        for (int k = PIN_SLOTS - 1; k >= 0; k--) begin
            if (!r_pv[k]) begin
                pin_free_ok = 1'b1;
                pin_free_idx = PW'(k);
            end
        end
    end

    logic [63:0] cnt_inc;
    assign cnt_inc = r_cnt + 64'd1;

    always_comb begin
        e_ra = ii;
        p_ra = pp;
        unique case (r_st)
            S_EVRD, S_EVWT, S_EVOUT: e_ra = r_best;
            S_PINCK: e_ra = ii;
            default: e_ra = ii;
        endcase
        e_we = 1'b0;
        e_wa = r_hit_idx;
        e_wd = {cnt_inc, (r_cmd.command == CMD_INSERT) ? r_cmd.item_bytes : r_hit_size,
                r_cmd.item_id};
        p_we = (r_st == S_PINFW) && !r_found && pin_free_ok && (r_p == PIN_SLOTS);
        p_wa = pin_free_idx;
        p_wd = r_cmd.item_id;
        if (r_st == S_WRITE) e_we = 1'b1;
        if (r_st == S_DONE && r_cmd.command == CMD_TOUCH && r_found) begin
            e_we = 1'b0;
        end
    end

    function automatic logic hit_now();
        logic h;
        h = 1'b0;
        if (r_cmd.command == CMD_TOUCH || r_cmd.command == CMD_LOOKUP) h = r_found;
        if (r_cmd.command == CMD_INSERT) h = (r_status != ST_FULL) && r_ev[r_hit_idx];
        return h;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_budget <= BUDGET_RESET;
            r_total <= '0;
            r_cnt <= '0;
            r_ev <= '0;
            r_er <= '0;
            r_pv <= '0;
            r_rv <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_BUDGET) r_budget <= pwdata[36:0];
            if (r_rv && o_res.ready) r_rv <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd <= i_cmd.data;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_nev <= '0;
                        r_status <= ST_OK;
                        r_st <= S_FIND;
                    end
                end
                S_FIND: r_st <= S_FINDW;
                S_FINDW: begin
                    if (r_ev[ii] && rd_key == r_cmd.item_id && !r_found) begin
                        r_found <= 1'b1;
                        r_hit_idx <= ii;
                        r_hit_size <= rd_size;
                    end
                    if (r_i == ENTRIES - 1) begin
                        r_st <= S_DISP;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_FIND;
                    end
                end
                S_DISP: begin
                    r_i <= '0;
                    r_has_best <= 1'b0;
                    r_p <= '0;
                    unique case (r_cmd.command)
                        CMD_INSERT: begin
                            if (r_found) begin
                                r_total <= r_total - {5'd0, r_hit_size};
                                r_st <= S_WRITE;
                            end else if (free_ok) begin
                                r_hit_idx <= free_idx;
                                r_er[free_idx] <= 1'b0;
                                r_st <= S_WRITE;
                            end else begin
                                r_goal <= G_INS;
                                r_st <= S_LRU;
                            end
                        end
                        CMD_TOUCH, CMD_LOOKUP, CMD_RETAIN: begin
                            if (!r_found) r_status <= ST_MISS;
                            else if (r_cmd.command == CMD_RETAIN) r_er[r_hit_idx] <= 1'b1;
                            if (r_found && r_cmd.command == CMD_TOUCH) begin
                                r_st <= S_WRITE;
                            end else begin
                                r_st <= S_DONE;
                            end
                        end
                        CMD_CLRPIN: begin
                            r_pv <= '0;
                            r_goal <= G_TRIM;
                            r_st <= S_LRU;
                        end
                        CMD_ADDPIN: begin
                            r_found <= 1'b0;
                            r_st <= S_PINFD;
                        end
                        CMD_TRIM: begin
                            r_goal <= G_TRIM;
                            r_st <= S_LRU;
                        end
                        CMD_REMOVE: begin
                            r_goal <= G_REM;
                            r_st <= S_LRU;
                        end
                        CMD_CLEAR: begin
                            r_ev <= '0;
                            r_er <= '0;
                            r_pv <= '0;
                            r_total <= '0;
                            r_st <= S_DONE;
                        end
                        default: r_st <= S_DONE;
                    endcase
                end
                S_PINFD: r_st <= S_PINFW;
                S_PINFW: begin
                    if (r_p == PIN_SLOTS) begin
                        if (!r_found) begin
                            if (pin_free_ok) r_pv[pin_free_idx] <= 1'b1;
                            else r_status <= ST_PINFULL;
                        end
                        r_goal <= G_TRIM;
                        r_p <= '0;
                        r_st <= S_LRU;
                    end else begin
                        if (r_pv[pp] && p_rd == r_cmd.item_id) r_found <= 1'b1;
                        r_p <= r_p + 1'b1;
                        r_st <= (r_p + 1'b1 == PIN_SLOTS) ? S_PINFW : S_PINFD;
                    end
                end
                S_LRU: begin
                    if (r_goal == G_TRIM && r_i == '0 && !r_has_best &&
                        !(r_total > r_budget && r_nev < ENTRIES)) begin
                        r_st <= S_DONE;
                    end else if (r_i == ENTRIES) begin
                        r_st <= S_LRUN;
                    end else if (!r_ev[ii]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_p <= '0;
                        r_pinned <= 1'b0;
                        r_st <= S_PINCK;
                    end
                end
                S_PINCK: r_st <= S_PINW;
                S_PINW: begin
                    if (r_p == PIN_SLOTS) begin
                        if (r_goal == G_REM) begin
                            if (!r_pinned && !r_er[ii]) begin
                                r_best <= ii;
                                r_st <= S_EVRD;
                            end else begin
                                r_i <= r_i + 1'b1;
                                r_st <= S_LRU;
                            end
                        end else begin
                            if (!r_pinned && (!r_has_best || rd_stamp < r_best_st)) begin
                                r_best <= ii;
                                r_best_st <= rd_stamp;
                                r_has_best <= 1'b1;
                            end
                            r_i <= r_i + 1'b1;
                            r_st <= S_LRU;
                        end
                    end else begin
                        if (r_pv[pp] && p_rd == rd_key) r_pinned <= 1'b1;
                        r_p <= r_p + 1'b1;
                        r_st <= (r_p + 1'b1 == PIN_SLOTS) ? S_PINW : S_PINCK;
                    end
                end
                S_LRUN: begin
                    if (r_goal == G_REM) begin
                        r_er <= '0;
                        r_st <= S_DONE;
                    end else if (!r_has_best) begin
                        if (r_goal == G_INS) r_status <= ST_FULL;
                        r_st <= S_DONE;
                    end else begin
                        r_st <= S_EVRD;
                    end
                end
                S_EVRD: r_st <= S_EVWT;
                S_EVWT: r_st <= S_EVOUT;
                S_EVOUT: begin
                    if (!r_rv) begin
                        r_ev[r_best] <= 1'b0;
                        r_er[r_best] <= 1'b0;
                        r_total <= r_total - {5'd0, rd_size};
                        r_res <= '{result_kind: 1'b0, result_id: rd_key, hit: 1'b0,
                                   byte_total: r_total - {5'd0, rd_size},
                                   status: ST_OK, last: 1'b0};
                        r_rv <= 1'b1;
                        r_nev <= r_nev + 1'b1;
                        r_has_best <= 1'b0;
                        if (r_goal == G_INS) begin
                            r_hit_idx <= r_best;
                            r_st <= S_WRITE;
                        end else if (r_goal == G_REM) begin
                            r_i <= r_i + 1'b1;
                            r_st <= S_LRU;
                        end else begin
                            r_i <= '0;
                            r_st <= S_LRU;
                        end
                    end
                end
                S_WRITE: begin
                    r_cnt <= cnt_inc;
                    if (r_cmd.command == CMD_INSERT) begin
                        r_ev[r_hit_idx] <= 1'b1;
                        if (!r_found) r_er[r_hit_idx] <= 1'b0;
                        r_total <= r_total + {5'd0, r_cmd.item_bytes};
                        r_goal <= G_TRIM;
                        r_i <= '0;
                        r_has_best <= 1'b0;
                        r_st <= S_LRU;
                    end else begin
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_rv) begin
                        r_res <= '{result_kind: 1'b1, result_id: r_cmd.item_id,
                                   hit: hit_now(), byte_total: r_total,
                                   status: r_status, last: 1'b1};
                        r_rv <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/bblc_checker.sv
// Checker for the byte budget LRU cache: predicts each command's results and compares.
`timescale 1ns / 100ps
module bblc_checker import bblc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bblc_cmd_if              cmd,
    bblc_res_if              res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending
);
    logic [36:0] budget;
    bit          ent_valid [ENTRIES];
    logic [31:0] ent_key   [ENTRIES];
    logic [31:0] ent_size  [ENTRIES];
    logic [63:0] ent_stamp [ENTRIES];
    bit          ent_keep  [ENTRIES];
    bit          pin_valid [PIN_SLOTS];
    logic [31:0] pin_key   [PIN_SLOTS];
    logic [36:0] total;
    logic [63:0] use_count;
    int          n_evict;
    t_res        expected_q[$];

    function automatic bit is_pinned(logic [31:0] k);
        for (int i = 0; i < PIN_SLOTS; i++)
            if (pin_valid[i] && pin_key[i] == k) return 1;
        return 0;
    endfunction

    function automatic int slot_of(logic [31:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (ent_valid[i] && ent_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void push_result(bit kind, logic [31:0] id, bit h,
                                        logic [1:0] st);
        t_res r;
        r.result_kind    = kind;
        r.result_id      = id;
        r.hit            = h;
        r.byte_total     = total;
        r.status         = st;
        r.last           = kind;
        expected_q.push_back(r);
    endfunction

    function automatic void evict_slot(int i);
        total        = total - {5'd0, ent_size[i]};
        ent_valid[i] = 0;
        ent_keep[i]  = 0;
        n_evict++;
        push_result(1'b0, ent_key[i], 1'b0, ST_OK);
    endfunction

    function automatic int oldest_unpinned();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!ent_valid[i] || is_pinned(ent_key[i])) continue;
            if (best < 0 || ent_stamp[i] < ent_stamp[best]) best = i;
        end
        return best;
    endfunction

    function automatic void trim_to_budget();
        int v;
        while (total > budget && n_evict < ENTRIES) begin
            v = oldest_unpinned();
            if (v < 0) break;
            evict_slot(v);
        end
    endfunction

    function automatic void predict_command(t_cmd c);
        int         idx;
        int         ps;
        bit         h;
        logic [1:0] st;
        h = 0;
        st = ST_OK;
        n_evict = 0;
        case (c.command)
            CMD_INSERT: begin
                idx = slot_of(c.item_id);
                if (idx >= 0) begin
                    total = total - {5'd0, ent_size[idx]};
                end else begin
                    for (int i = 0; i < ENTRIES && idx < 0; i++)
                        if (!ent_valid[i]) idx = i;
                    if (idx < 0) begin
                        idx = oldest_unpinned();
                        if (idx >= 0) evict_slot(idx);
                    end
                    if (idx >= 0) begin
                        ent_valid[idx] = 1;
                        ent_key[idx]   = c.item_id;
                        ent_keep[idx]  = 0;
                    end
                end
                if (idx < 0) begin
                    st = ST_FULL;
                end else begin
                    ent_size[idx] = c.item_bytes;
                    total = total + {5'd0, c.item_bytes};
                    use_count++;
                    ent_stamp[idx] = use_count;
                    trim_to_budget();
                    h = slot_of(c.item_id) >= 0;
                end
            end
            CMD_TOUCH: begin
                idx = slot_of(c.item_id);
                if (idx >= 0) begin
                    use_count++;
                    ent_stamp[idx] = use_count;
                    h = 1;
                end else st = ST_MISS;
            end
            CMD_LOOKUP: begin
                if (slot_of(c.item_id) >= 0) h = 1;
                else st = ST_MISS;
            end
            CMD_CLRPIN: begin
                foreach (pin_valid[i]) pin_valid[i] = 0;
                trim_to_budget();
            end
            CMD_ADDPIN: begin
                if (!is_pinned(c.item_id)) begin
                    ps = -1;
                    for (int i = 0; i < PIN_SLOTS && ps < 0; i++)
                        if (!pin_valid[i]) ps = i;
                    if (ps < 0) st = ST_PINFULL;
                    else begin
                        pin_valid[ps] = 1;
                        pin_key[ps]   = c.item_id;
                    end
                end
                trim_to_budget();
            end
            CMD_TRIM: trim_to_budget();
            CMD_RETAIN: begin
                idx = slot_of(c.item_id);
                if (idx >= 0) ent_keep[idx] = 1;
                else st = ST_MISS;
            end
            CMD_REMOVE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (ent_valid[i] && !ent_keep[i] && !is_pinned(ent_key[i]))
                        evict_slot(i);
                foreach (ent_keep[i]) ent_keep[i] = 0;
            end
            CMD_CLEAR: begin
                foreach (ent_valid[i]) ent_valid[i] = 0;
                foreach (ent_keep[i]) ent_keep[i] = 0;
                foreach (pin_valid[i]) pin_valid[i] = 0;
                total = '0;
            end
            default: ;
        endcase
        push_result(1'b1, c.item_id, h, st);
    endfunction

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (!i_rst_n) begin
            budget    = BUDGET_RESET;
            total     = '0;
            use_count = '0;
            foreach (ent_valid[i]) ent_valid[i] = 0;
            foreach (ent_keep[i]) ent_keep[i] = 0;
            foreach (pin_valid[i]) pin_valid[i] = 0;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_BUDGET)
                budget = pwdata[36:0];
            if (res.valid && res.ready) begin
                got = res.data;
                if (expected_q.size() == 0) begin
                    $error("unexpected result word id=%h", got.result_id);
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.result_kind !== exp_r.result_kind) begin
                        $error("result_kind exp %0d got %0d", exp_r.result_kind,
                               got.result_kind);
                        o_fail_count++;
                    end
                    if (got.result_id !== exp_r.result_id) begin
                        $error("result_id exp %h got %h", exp_r.result_id, got.result_id);
                        o_fail_count++;
                    end
                    if (got.hit !== exp_r.hit) begin
                        $error("hit exp %0d got %0d", exp_r.hit, got.hit);
                        o_fail_count++;
                    end
                    if (got.byte_total !== exp_r.byte_total) begin
                        $error("byte_total exp %0d got %0d", exp_r.byte_total,
                               got.byte_total);
                        o_fail_count++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                        o_fail_count++;
                    end
                    if (got.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, got.last);
                        o_fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready) predict_command(cmd.data);
        end
        o_pending = expected_q.size();
    end
endmodule

### tb/tb_top.sv
// Testbench top for the byte budget LRU cache: stimulus, config writes and verdict.
`timescale 1ns / 100ps
module tb_top;
    import bblc_pkg::*;

    localparam longint CYCLE_LIMIT = 100_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    longint      cycles = 0;
    int          burst_left;
    logic [31:0] key_pool [40];

    bblc_cmd_if cmd_ch ();
    bblc_res_if res_ch ();

    byte_budget_lru_cache u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bblc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd          (cmd_ch),
        .res          (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_done && cycles > 20000) begin
                long_done = 1;
                hold = 3000;
            end else if (hold == 0 && $urandom_range(0, 19) == 0) begin
                hold = $urandom_range(1, 40);
            end
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (cycles % 2000 < 600) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    task automatic write_budget(logic [36:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BUDGET;
        pwdata  <= {27'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(logic [3:0] op, logic [31:0] id, logic [31:0] nbytes);
        int gap;
        if (burst_left == 0) begin
            cmd_ch.valid <= 1'b0;
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 15);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= '{command: op, item_id: id, item_bytes: nbytes};
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 39)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 16);
            default: return $urandom_range(0, 32'h0200_0000);
        endcase
    endfunction

    function automatic logic [3:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return CMD_INSERT;
        if (r < 48) return CMD_TOUCH;
        if (r < 56) return CMD_LOOKUP;
        if (r < 59) return CMD_CLRPIN;
        if (r < 71) return CMD_ADDPIN;
        if (r < 77) return CMD_TRIM;
        if (r < 88) return CMD_RETAIN;
        if (r < 92) return CMD_REMOVE;
        if (r < 94) return CMD_CLEAR;
        return 4'($urandom_range(9, 15));
    endfunction

    initial begin
        logic [36:0] budgets [5];
        logic [3:0]  op;
        budgets = '{37'd268435456, 37'd1000000, 37'd0, 37'h1F_FFFF_FFFF, 37'd1 << 30};
        for (int i = 0; i < 38; i++) key_pool[i] = i * 32'h0101_0103;
        key_pool[38] = 32'h0;
        key_pool[39] = 32'hFFFF_FFFF;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(CMD_INSERT, 32'h0, 32'h0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'h5, 32'h0FFF_FFFF);
        send_word(CMD_INSERT, 32'h6, 32'h10);
        send_word(CMD_LOOKUP, 32'h5, 32'h0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_word(CMD_TOUCH, 32'h5, 32'h0);
        send_word(CMD_TOUCH, 32'h1234_5678, 32'h0);
        send_word(CMD_RETAIN, 32'h9999_9999, 32'h0);
        send_word(CMD_ADDPIN, 32'h6, 32'h0);
        send_word(CMD_ADDPIN, 32'h6, 32'h0);
        send_word(CMD_INSERT, 32'h6, 32'hFFFF_FFFF);
        send_word(CMD_INSERT, 32'h5, 32'h100);
        send_word(CMD_TRIM, 32'h0, 32'h0);
        send_word(CMD_CLRPIN, 32'h0, 32'h0);
        send_word(CMD_INSERT, 32'h7, 32'h20);
        send_word(CMD_RETAIN, 32'h7, 32'h0);
        send_word(CMD_REMOVE, 32'h0, 32'h0);
        send_word(4'd9, 32'hAAAA_5555, 32'h5555_AAAA);
        send_word(4'd15, 32'h5555_AAAA, 32'hAAAA_5555);
        send_word(CMD_CLEAR, 32'h0, 32'h0);
        drain();

        foreach (budgets[p]) begin
            write_budget(budgets[p]);
            for (int n = 0; n < 80; n++) begin
                op = pick_op();
                send_word(op, pick_key(), pick_size());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

### sim.f
rtl/bblc_pkg.sv
rtl/bblc_if.sv
rtl/bblc_ram.sv
rtl/byte_budget_lru_cache.sv
tb/bblc_checker.sv
tb/tb_top.sv
